/* rtl/core/hkc_pkg.sv */
// Hangul keypad syllable composer package: composition modes, jamo code
// table, multi-tap tables and their lookup functions. No dependencies.
package hkc_pkg;

   localparam int KeyWidth  = 6;
   localparam int SlotWidth = 7;
   localparam int CodeWidth = 16;

   localparam logic [1:0] KIND_JAMO  = 2'd0;
   localparam logic [1:0] KIND_SPACE = 2'd1;
   localparam logic [1:0] KIND_ENTER = 2'd2;
   localparam logic [1:0] KIND_BKSP  = 2'd3;

   localparam logic [2:0] MODE_EMPTY = 3'd0;
   localparam logic [2:0] MODE_CONS  = 3'd1;
   localparam logic [2:0] MODE_VOWEL = 3'd2;
   localparam logic [2:0] MODE_SYL   = 3'd3;
   localparam logic [2:0] MODE_FIN   = 3'd4;
   localparam logic [2:0] MODE_CMPD  = 3'd5;

   localparam logic [CodeWidth-1:0] SYL_BASE   = 16'hAC00;
   localparam logic [CodeWidth-1:0] SPACE_CODE = 16'h0020;
   localparam logic [SlotWidth-1:0] NO_FINAL   = 7'd40;
   localparam logic [SlotWidth-1:0] LAST_CONS  = 7'd18;
   localparam logic [SlotWidth-1:0] LAST_JAMO  = 7'd39;

   typedef struct packed {
      logic                 hit;
      logic [SlotWidth-1:0] value;
   } tap_type;

   typedef struct packed {
      logic                 hit;
      logic [SlotWidth-1:0] part_one;
      logic [SlotWidth-1:0] part_two;
   } split_type;

   localparam logic [CodeWidth-1:0] JAMO_UC [40] = '{
      16'h3131, 16'h3132, 16'h3134, 16'h3137, 16'h3138, 16'h3139, 16'h3141,
      16'h3142, 16'h3143, 16'h3145, 16'h3146, 16'h3147, 16'h3148, 16'h3149,
      16'h314A, 16'h314B, 16'h314C, 16'h314D, 16'h314E,
      16'h314F, 16'h3150, 16'h3151, 16'h3152, 16'h3153, 16'h3154, 16'h3155,
      16'h3156, 16'h3157, 16'h3158, 16'h3159, 16'h315A, 16'h315B, 16'h315C,
      16'h315D, 16'h315E, 16'h315F, 16'h3160, 16'h3161, 16'h3162, 16'h3163
   };

   localparam int KEY_TO_FIN [19] = '{
      41, 42, 44, 47, 0, 48, 56, 57, 0, 59, 60, 61, 62, 0, 63, 64, 65, 66, 67
   };

   localparam int TAP_INI [14][3] = '{
      '{0, 0, 15}, '{15, 0, 1}, '{1, 0, 0},
      '{3, 3, 16}, '{16, 3, 4}, '{4, 3, 3},
      '{7, 7, 17}, '{17, 7, 8}, '{8, 7, 7},
      '{9, 9, 10}, '{10, 9, 9},
      '{12, 12, 14}, '{14, 12, 13}, '{13, 12, 12}
   };

   localparam int TAP_VOW [21][3] = '{
      '{19, 19, 21}, '{21, 19, 19}, '{19, 39, 20}, '{21, 39, 22},
      '{23, 23, 25}, '{25, 23, 23}, '{23, 39, 24}, '{25, 39, 26},
      '{27, 27, 31}, '{31, 27, 27}, '{27, 19, 28}, '{28, 39, 29},
      '{27, 39, 30}, '{32, 32, 36}, '{36, 32, 32}, '{32, 23, 33},
      '{33, 39, 34}, '{32, 39, 35}, '{39, 39, 37}, '{37, 39, 38},
      '{38, 39, 39}
   };

   localparam int TAP_FIN [22][3] = '{
      '{41, 41, 64}, '{64, 41, 42}, '{42, 41, 41}, '{41, 59, 43},
      '{44, 62, 45}, '{44, 67, 46}, '{47, 47, 65}, '{65, 47, 47},
      '{48, 41, 49}, '{48, 56, 50}, '{48, 57, 51}, '{51, 57, 54},
      '{48, 59, 52}, '{48, 47, 53}, '{48, 67, 55}, '{57, 57, 66},
      '{66, 57, 57}, '{57, 59, 58}, '{59, 59, 60}, '{60, 59, 59},
      '{62, 62, 63}, '{63, 62, 62}
   };

   localparam int SPLIT_FIN [13][3] = '{
      '{41, 41, 42}, '{41, 59, 43}, '{44, 62, 45}, '{44, 67, 46},
      '{48, 41, 49}, '{48, 56, 50}, '{48, 57, 51}, '{48, 66, 54},
      '{48, 59, 52}, '{48, 65, 53}, '{48, 67, 55}, '{57, 59, 58},
      '{59, 59, 60}
   };

   function automatic logic [CodeWidth-1:0] jamo_code(input logic [SlotWidth-1:0] idx);
      logic [CodeWidth-1:0] r;
      r = '0;
      if (idx <= LAST_JAMO) begin
         r = JAMO_UC[idx[5:0]];
      end
      return r;
   endfunction

   function automatic logic [SlotWidth-1:0] key_to_fin(input logic [SlotWidth-1:0] key);
      logic [SlotWidth-1:0] r;
      r = '0;
      if (key <= LAST_CONS) begin
         r = SlotWidth'(KEY_TO_FIN[key[4:0]]);
      end
      return r;
   endfunction

   function automatic logic [SlotWidth-1:0] fin_to_ini(input logic [SlotWidth-1:0] f);
      logic [SlotWidth-1:0] r;
      case (f)
         7'd42:   r = 7'd1;
         7'd44:   r = 7'd2;
         7'd47:   r = 7'd3;
         7'd48:   r = 7'd5;
         7'd56:   r = 7'd6;
         7'd57:   r = 7'd7;
         7'd59:   r = 7'd9;
         7'd60:   r = 7'd10;
         7'd61:   r = 7'd11;
         7'd62:   r = 7'd12;
         7'd63:   r = 7'd14;
         7'd64:   r = 7'd15;
         7'd65:   r = 7'd16;
         7'd66:   r = 7'd17;
         7'd67:   r = 7'd18;
         default: r = 7'd0;
      endcase
      return r;
   endfunction

   function automatic tap_type tap_ini(input logic [SlotWidth-1:0] slot,
                                       input logic [SlotWidth-1:0] key);
      tap_type r;
      r = '0;
      for (int i = 13; i >= 0; i--) begin
         if (slot == SlotWidth'(TAP_INI[i][0]) && key == SlotWidth'(TAP_INI[i][1])) begin
            r.hit   = 1'b1;
            r.value = SlotWidth'(TAP_INI[i][2]);
         end
      end
      return r;
   endfunction

   function automatic tap_type tap_vow(input logic [SlotWidth-1:0] slot,
                                       input logic [SlotWidth-1:0] key);
      tap_type r;
      r = '0;
      for (int i = 20; i >= 0; i--) begin
         if (slot == SlotWidth'(TAP_VOW[i][0]) && key == SlotWidth'(TAP_VOW[i][1])) begin
            r.hit   = 1'b1;
            r.value = SlotWidth'(TAP_VOW[i][2]);
         end
      end
      return r;
   endfunction

   function automatic tap_type tap_fin(input logic [SlotWidth-1:0] slot,
                                       input logic [SlotWidth-1:0] fin);
      tap_type r;
      r = '0;
      for (int i = 21; i >= 0; i--) begin
         if (slot == SlotWidth'(TAP_FIN[i][0]) && fin == SlotWidth'(TAP_FIN[i][1])) begin
            r.hit   = 1'b1;
            r.value = SlotWidth'(TAP_FIN[i][2]);
         end
      end
      return r;
   endfunction

   function automatic split_type split_fin(input logic [SlotWidth-1:0] fin);
      split_type r;
      r = '0;
      for (int i = 12; i >= 0; i--) begin
         if (fin == SlotWidth'(SPLIT_FIN[i][2])) begin
            r.hit      = 1'b1;
            r.part_one = SlotWidth'(SPLIT_FIN[i][0]);
            r.part_two = SlotWidth'(SPLIT_FIN[i][1]);
         end
      end
      return r;
   endfunction

   // base + ini*588 + vow*28 + fin - 572, modulo 2^16
   function automatic logic [CodeWidth-1:0] syllable(input logic [SlotWidth-1:0] ini,
                                                      input logic [SlotWidth-1:0] vow,
                                                      input logic [SlotWidth-1:0] fin);
      logic [CodeWidth-1:0] a;
      logic [CodeWidth-1:0] b;
      a = CodeWidth'(ini) * 16'd588;
      b = CodeWidth'(vow) * 16'd28;
      return SYL_BASE + a + b + CodeWidth'(fin) - 16'd572;
   endfunction

endpackage

/* rtl/core/hangul_keypad_syllable_composer.sv */
// Hangul keypad syllable composer: composition state machine and result register.
// Depends on hkc_pkg for modes, jamo tables and lookup functions.
//
//   channel | ports                          | direction
//   req     | req_valid/ready, kind, jamo_key| in
//   rsp     | rsp_valid/ready, commit_char,  | out
//           | newline, erase_previous,       |
//           | preview_char                   |
//
// One request per cycle while no response is stalled; its response appears in the following cycle.
// The next state is computed combinationally: lookups are small constant tables.
// Reset empties the composition and drops any pending response.
// A stalled response holds req_ready low only while it is not being taken.
module hangul_keypad_syllable_composer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_kind,
   input  logic [hkc_pkg::KeyWidth-1:0]  req_jamo_key,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [hkc_pkg::CodeWidth-1:0] rsp_commit_char,
   output logic                          rsp_newline,
   output logic                          rsp_erase_previous,
   output logic [hkc_pkg::CodeWidth-1:0] rsp_preview_char
);
   import hkc_pkg::*;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           mode_ff, mode_in;
   logic [SlotWidth-1:0] ini_ff, ini_in;
   logic [SlotWidth-1:0] vow_ff, vow_in;
   logic [SlotWidth-1:0] fin_ff, fin_in;
   logic [CodeWidth-1:0] preview_ff, preview_in;
   logic [CodeWidth-1:0] commit_ff, commit_in;
   logic                 newline_ff, newline_in;
   logic                 erase_ff, erase_in;

   logic                 accept;
   logic [SlotWidth-1:0] key;
   logic                 is_vow;
   logic [SlotWidth-1:0] kf;
   logic [CodeWidth-1:0] syl_open;
   tap_type              t_ini;
   tap_type              t_vow_ini;
   tap_type              t_vow_vow;
   tap_type              t_fin;
   split_type            sp;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign key       = SlotWidth'(req_jamo_key);
   assign is_vow    = key > LAST_CONS;
   assign kf        = key_to_fin(key);
   assign syl_open  = syllable(ini_ff, vow_ff, NO_FINAL);
   assign t_ini     = tap_ini(ini_ff, key);
   assign t_vow_ini = tap_vow(ini_ff, key);
   assign t_vow_vow = tap_vow(vow_ff, key);
   assign t_fin     = tap_fin(fin_ff, kf);
   assign sp        = split_fin(fin_ff);

   always_comb begin
      mode_in    = mode_ff;
      ini_in     = ini_ff;
      vow_in     = vow_ff;
      fin_in     = fin_ff;
      preview_in = preview_ff;
      commit_in  = '0;
      newline_in = 1'b0;
      erase_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         rsp_valid_in = 1'b1;
         case (req_kind)
            KIND_SPACE: begin
               mode_in    = MODE_EMPTY;
               commit_in  = (preview_ff != '0) ? preview_ff : SPACE_CODE;
               preview_in = '0;
            end
            KIND_ENTER: begin
               mode_in    = MODE_EMPTY;
               commit_in  = preview_ff;
               newline_in = 1'b1;
               preview_in = '0;
            end
            KIND_BKSP: begin
               mode_in = MODE_EMPTY;
               if (preview_ff == '0) begin
                  erase_in = 1'b1;
               end else if (mode_ff == MODE_SYL) begin
                  preview_in = jamo_code(ini_ff);
                  mode_in    = MODE_CONS;
               end else if (mode_ff == MODE_FIN || mode_ff == MODE_CMPD) begin
                  if (sp.hit) begin
                     fin_in     = sp.part_one;
                     preview_in = syllable(ini_ff, vow_ff, sp.part_one);
                     mode_in    = MODE_CMPD;
                  end else begin
                     preview_in = syl_open;
                     mode_in    = MODE_SYL;
                  end
               end else begin
                  preview_in = '0;
               end
            end
            default: begin
               if (key <= LAST_JAMO) begin
                  unique case (mode_ff)
                     MODE_CONS: begin
                        if (is_vow) begin
                           vow_in  = key;
                           mode_in = MODE_SYL;
                        end else if (t_ini.hit) begin
                           ini_in = t_ini.value;
                        end else begin
                           commit_in = jamo_code(ini_ff);
                           ini_in    = key;
                        end
                     end
                     MODE_VOWEL: begin
                        if (is_vow && t_vow_ini.hit) begin
                           ini_in = t_vow_ini.value;
                        end else begin
                           commit_in = jamo_code(ini_ff);
                           ini_in    = key;
                           if (!is_vow) begin
                              mode_in = MODE_CONS;
                           end
                        end
                     end
                     MODE_SYL: begin
                        if (is_vow) begin
                           if (t_vow_vow.hit) begin
                              vow_in = t_vow_vow.value;
                           end else begin
                              commit_in = syl_open;
                              ini_in    = key;
                              mode_in   = MODE_VOWEL;
                           end
                        end else if (kf != '0) begin
                           fin_in  = kf;
                           mode_in = MODE_FIN;
                        end else begin
                           commit_in = syl_open;
                           ini_in    = key;
                           mode_in   = MODE_CONS;
                        end
                     end
                     MODE_FIN, MODE_CMPD: begin
                        if (is_vow) begin
                           vow_in  = key;
                           mode_in = MODE_SYL;
                           if (mode_ff == MODE_CMPD && sp.hit) begin
                              commit_in = syllable(ini_ff, vow_ff, sp.part_one);
                              ini_in    = fin_to_ini(sp.part_two);
                           end else begin
                              commit_in = syl_open;
                              ini_in    = fin_to_ini(fin_ff);
                           end
                        end else if (kf != '0 && t_fin.hit) begin
                           fin_in  = t_fin.value;
                           mode_in = MODE_CMPD;
                        end else begin
                           commit_in = syllable(ini_ff, vow_ff, fin_ff);
                           ini_in    = key;
                           mode_in   = MODE_CONS;
                        end
                     end
                     default: begin
                        ini_in  = key;
                        mode_in = is_vow ? MODE_VOWEL : MODE_CONS;
                     end
                  endcase
                  if (mode_in == MODE_SYL) begin
                     preview_in = syllable(ini_in, vow_in, NO_FINAL);
                  end else if (mode_in == MODE_FIN || mode_in == MODE_CMPD) begin
                     preview_in = syllable(ini_in, vow_in, fin_in);
                  end else begin
                     preview_in = jamo_code(ini_in);
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_EMPTY;
         ini_ff       <= '0;
         vow_ff       <= '0;
         fin_ff       <= '0;
         preview_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         ini_ff       <= ini_in;
         vow_ff       <= vow_in;
         fin_ff       <= fin_in;
         preview_ff   <= preview_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         commit_ff  <= commit_in;
         newline_ff <= newline_in;
         erase_ff   <= erase_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_commit_char    = commit_ff;
   assign rsp_newline        = newline_ff;
   assign rsp_erase_previous = erase_ff;
   assign rsp_preview_char   = preview_ff;

endmodule

/* tb/sv/tb.sv */
// Testbench for hangul_keypad_syllable_composer: queued key events drive the
// request channel, an in-bench composer model predicts each response.
// Depends on hkc_pkg and the composer RTL.
module tb;
   import hkc_pkg::*;

   typedef struct packed {
      logic [1:0]          kind;
      logic [KeyWidth-1:0] key;
   } key_event_type;

   typedef struct packed {
      logic [CodeWidth-1:0] commit;
      logic                 newline;
      logic                 erase;
      logic [CodeWidth-1:0] preview;
   } composer_out_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_kind = KIND_JAMO;
   logic [KeyWidth-1:0]  req_jamo_key = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [CodeWidth-1:0] rsp_commit_char;
   logic                 rsp_newline;
   logic                 rsp_erase_previous;
   logic [CodeWidth-1:0] rsp_preview_char;

   key_event_type    pending_events[$];
   composer_out_type expected_outputs[$];
   int               failures = 0;

   hangul_keypad_syllable_composer DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // composer model state
   logic [2:0]           m_mode = MODE_EMPTY;
   logic [SlotWidth-1:0] m_ini = '0, m_vow = '0, m_fin = '0, m_p1 = '0, m_p2 = '0;
   logic [CodeWidth-1:0] m_preview = '0;

   function automatic logic [CodeWidth-1:0] compose_code(input int ini, vow, fin);
      return CodeWidth'(32'hAC00 + ini * 588 + vow * 28 + fin - 572);
   endfunction

   function automatic int final_as_initial(input int f);
      case (f)
         42: return 1;  44: return 2;  47: return 3;  48: return 5;
         56: return 6;  57: return 7;  59: return 9;  60: return 10;
         61: return 11; 62: return 12; 63: return 14; 64: return 15;
         65: return 16; 66: return 17; 67: return 18;
         default: return 0;
      endcase
   endfunction

   function automatic int find_split(input int f);
      for (int i = 0; i < 13; i++)
         if (SPLIT_FIN[i][2] == f) return i;
      return -1;
   endfunction

   task automatic tap_final_slot(input int f, output bit hit);
      hit = 0;
      for (int i = 0; i < 22; i++) begin
         if (!hit && TAP_FIN[i][0] == m_fin && TAP_FIN[i][1] == f) begin
            m_p1 = m_fin;
            m_p2 = SlotWidth'(f);
            m_fin = SlotWidth'(TAP_FIN[i][2]);
            hit = 1;
         end
      end
   endtask

   task automatic consonant_after_final(input int key, output logic [CodeWidth-1:0] c);
      int f;
      bit hit;
      f = KEY_TO_FIN[key];
      hit = 0;
      c = '0;
      if (f != 0) tap_final_slot(f, hit);
      if (hit) begin
         m_mode = MODE_CMPD;
      end else begin
         c = compose_code(m_ini, m_vow, m_fin);
         m_ini = SlotWidth'(key);
         m_mode = MODE_CONS;
      end
   endtask

   task automatic backspace_split();
      int total, last, s;
      if (m_preview < 16'hAC00 || m_preview > 16'hD7A3) begin
         m_preview = '0;
         m_mode = MODE_EMPTY;
         return;
      end
      total = m_preview - 16'hAC00;
      m_ini = SlotWidth'(total / 588);
      last = total % 28;
      if (last == 0) begin
         m_preview = JAMO_UC[m_ini];
         m_mode = MODE_CONS;
         return;
      end
      m_vow = SlotWidth'((total / 28) % 21 + 19);
      s = find_split(last + 40);
      if (s >= 0) begin
         m_fin = SlotWidth'(SPLIT_FIN[s][0]);
         m_p1 = SlotWidth'(SPLIT_FIN[s][0]);
         m_p2 = SlotWidth'(SPLIT_FIN[s][1]);
         m_preview = compose_code(m_ini, m_vow, m_fin);
         m_mode = MODE_CMPD;
      end else begin
         m_preview = compose_code(m_ini, m_vow, 40);
         m_mode = MODE_SYL;
      end
   endtask

   task automatic compose_key_event(input key_event_type ev, output composer_out_type r);
      int  key, s;
      bit  vowel, hit;
      int  slot;
      key = ev.key;
      r = '0;
      if (ev.kind != KIND_JAMO) begin
         m_mode = MODE_EMPTY;
         if (ev.kind == KIND_SPACE) begin
            r.commit = (m_preview != 0) ? m_preview : SPACE_CODE;
            m_preview = '0;
         end else if (ev.kind == KIND_ENTER) begin
            r.commit = m_preview;
            r.newline = 1'b1;
            m_preview = '0;
         end else if (m_preview == 0) begin
            r.erase = 1'b1;
         end else begin
            backspace_split();
         end
      end else if (key <= 39) begin
         vowel = key > 18;
         case (m_mode)
            MODE_CONS: begin
               if (vowel) begin
                  m_vow = SlotWidth'(key);
                  m_mode = MODE_SYL;
               end else begin
                  hit = 0;
                  for (int i = 0; i < 14; i++)
                     if (!hit && TAP_INI[i][0] == m_ini && TAP_INI[i][1] == key) begin
                        m_ini = SlotWidth'(TAP_INI[i][2]);
                        hit = 1;
                     end
                  if (!hit) begin
                     r.commit = JAMO_UC[m_ini];
                     m_ini = SlotWidth'(key);
                  end
               end
            end
            MODE_VOWEL, MODE_SYL: begin
               if (vowel) begin
                  slot = (m_mode == MODE_VOWEL) ? m_ini : m_vow;
                  hit = 0;
                  for (int i = 0; i < 21; i++)
                     if (!hit && TAP_VOW[i][0] == slot && TAP_VOW[i][1] == key) begin
                        slot = TAP_VOW[i][2];
                        hit = 1;
                     end
                  if (m_mode == MODE_VOWEL) begin
                     if (hit) m_ini = SlotWidth'(slot);
                     else begin
                        r.commit = JAMO_UC[m_ini];
                        m_ini = SlotWidth'(key);
                     end
                  end else begin
                     if (hit) m_vow = SlotWidth'(slot);
                     else begin
                        r.commit = compose_code(m_ini, m_vow, 40);
                        m_ini = SlotWidth'(key);
                        m_mode = MODE_VOWEL;
                     end
                  end
               end else if (m_mode == MODE_VOWEL) begin
                  r.commit = JAMO_UC[m_ini];
                  m_ini = SlotWidth'(key);
                  m_mode = MODE_CONS;
               end else if (KEY_TO_FIN[key] != 0) begin
                  m_fin = SlotWidth'(KEY_TO_FIN[key]);
                  m_mode = MODE_FIN;
               end else begin
                  r.commit = compose_code(m_ini, m_vow, 40);
                  m_ini = SlotWidth'(key);
                  m_mode = MODE_CONS;
               end
            end
            MODE_FIN: begin
               if (vowel) begin
                  r.commit = compose_code(m_ini, m_vow, 40);
                  m_ini = SlotWidth'(final_as_initial(m_fin));
                  m_vow = SlotWidth'(key);
                  m_mode = MODE_SYL;
               end else consonant_after_final(key, r.commit);
            end
            MODE_CMPD: begin
               if (vowel) begin
                  s = find_split(m_fin);
                  if (s >= 0) begin
                     m_p1 = SlotWidth'(SPLIT_FIN[s][0]);
                     m_p2 = SlotWidth'(SPLIT_FIN[s][1]);
                     r.commit = compose_code(m_ini, m_vow, m_p1);
                     m_ini = SlotWidth'(final_as_initial(m_p2));
                  end else begin
                     r.commit = compose_code(m_ini, m_vow, 40);
                     m_ini = SlotWidth'(final_as_initial(m_fin));
                  end
                  m_vow = SlotWidth'(key);
                  m_mode = MODE_SYL;
               end else consonant_after_final(key, r.commit);
            end
            default: begin
               m_ini = SlotWidth'(key);
               m_mode = vowel ? MODE_VOWEL : MODE_CONS;
            end
         endcase
         if (m_mode == MODE_SYL) m_preview = compose_code(m_ini, m_vow, 40);
         else if (m_mode == MODE_FIN || m_mode == MODE_CMPD)
            m_preview = compose_code(m_ini, m_vow, m_fin);
         else m_preview = JAMO_UC[m_ini];
      end
      r.preview = m_preview;
   endtask

   // driver: bursts and gaps
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      composer_out_type exp_out;
      logic             nv;
      key_event_type    ev;
      if (!reset) begin
         nv = req_valid;
         if (req_valid && req_ready) begin
            compose_key_event(key_event_type'({req_kind, req_jamo_key}), exp_out);
            expected_outputs.push_back(exp_out);
            nv = 1'b0;
         end
         if (!nv) begin
            if (gap_left > 0) gap_left--;
            else if (pending_events.size() > 0) begin
               ev = pending_events.pop_front();
               req_kind <= ev.kind;
               req_jamo_key <= ev.key;
               nv = 1'b1;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(30);
                  gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
               end
            end
         end
         req_valid <= nv;
      end
   end

   // monitor: own stall pattern plus one long hold-off
   int responses = 0, hold_off = 0, stall_phase = 0;
   always @(posedge clock) begin
      composer_out_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            responses++;
            if (expected_outputs.size() == 0) begin
               $error("response with no request outstanding");
               failures++;
            end else begin
               e = expected_outputs.pop_front();
               if (rsp_commit_char !== e.commit) begin
                  $error("commit_char expected %h actual %h", e.commit, rsp_commit_char);
                  failures++;
               end
               if (rsp_newline !== e.newline) begin
                  $error("newline expected %b actual %b", e.newline, rsp_newline);
                  failures++;
               end
               if (rsp_erase_previous !== e.erase) begin
                  $error("erase_previous expected %b actual %b", e.erase,
                         rsp_erase_previous);
                  failures++;
               end
               if (rsp_preview_char !== e.preview) begin
                  $error("preview_char expected %h actual %h", e.preview, rsp_preview_char);
                  failures++;
               end
            end
            if (responses == 400) hold_off = 300;
         end
         stall_phase++;
         if (hold_off > 0) begin
            hold_off--;
            rsp_ready <= 1'b0;
         end else if ((stall_phase / 200) % 3 == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(4) != 0) && (stall_phase % 7 != 3);
         end
      end
   end

   task automatic add_event(input logic [1:0] kind, input int key);
      pending_events.push_back(key_event_type'({kind, KeyWidth'(key)}));
   endtask

   initial begin
      int r, last_key, k, total_events;
      // directed: empty-state specials, taps, finals, compound finals, backspace
      add_event(KIND_SPACE, 0);
      add_event(KIND_ENTER, 0);
      add_event(KIND_BKSP, 0);
      add_event(KIND_JAMO, 63);
      add_event(KIND_JAMO, 40);
      add_event(KIND_JAMO, 0);
      add_event(KIND_JAMO, 0);
      add_event(KIND_JAMO, 19);
      add_event(KIND_JAMO, 4);
      add_event(KIND_JAMO, 39);
      add_event(KIND_JAMO, 5);
      add_event(KIND_JAMO, 0);
      add_event(KIND_BKSP, 0);
      add_event(KIND_JAMO, 23);
      add_event(KIND_JAMO, 2);
      add_event(KIND_JAMO, 12);
      add_event(KIND_JAMO, 27);
      add_event(KIND_JAMO, 18);
      add_event(KIND_BKSP, 0);
      add_event(KIND_BKSP, 0);
      add_event(KIND_BKSP, 0);
      add_event(KIND_JAMO, 39);
      add_event(KIND_BKSP, 0);
      add_event(KIND_JAMO, 13);
      add_event(KIND_ENTER, 0);
      last_key = 0;
      for (int i = 0; i < 1650; i++) begin
         r = $urandom_range(99);
         if (r < 62) begin
            k = ($urandom_range(9) < 4) ? last_key : $urandom_range(39);
            last_key = k;
            add_event(KIND_JAMO, k);
         end else if (r < 67) add_event(KIND_JAMO, $urandom_range(63, 40));
         else if (r < 76) add_event(KIND_SPACE, $urandom_range(63));
         else if (r < 84) add_event(KIND_ENTER, $urandom_range(63));
         else add_event(KIND_BKSP, $urandom_range(63));
      end
      total_events = pending_events.size();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (responses < total_events)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0 && expected_outputs.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end
endmodule

/* hangul_keypad_syllable_composer.f */
rtl/core/hkc_pkg.sv
rtl/core/hangul_keypad_syllable_composer.sv
tb/sv/tb.sv
